[sv/tmp_pkg.sv]
// shared types and constants of the trapezoid motion profile unit
`timescale 1ns / 1ps
`default_nettype none

package tmp_pkg;

  localparam int Q_W = 32;          // register, position and time word
  localparam int MX_W = 41;         // saturated product, at most 2^40
  localparam int RMP_W = 40;        // half of a saturated product
  localparam int POS_W = 44;        // signed working position
  localparam int CFG_IDX_W = 1;

  typedef logic [Q_W-1:0] q_t;
  typedef logic [MX_W-1:0] mx_t;
  typedef logic signed [POS_W-1:0] pos_t;

  localparam mx_t SAT_CAP = {1'b1, {(MX_W-1){1'b0}}};
  localparam pos_t POS_HI = {{(POS_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
  localparam pos_t POS_LO = {{(POS_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};

  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXV = 1'b1;

  typedef struct packed {
    logic go;
    logic flush;
    logic op;
  } unit_req_t;

endpackage

`default_nettype wire

[sv/tmp_ifs.sv]
// valid/ready channel interfaces for the motion profile input and result beats
`timescale 1ns / 1ps
`default_nettype none

interface tmp_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic signed [31:0] start_position;
  logic signed [31:0] target_position;
  logic [31:0] sample_time;

  modport source(output valid, kind, start_position, target_position, sample_time,
                 input ready);
  modport sink(input valid, kind, start_position, target_position, sample_time,
               output ready);
endinterface

interface tmp_out_if;
  logic valid;
  logic ready;
  logic [31:0] move_duration;
  logic signed [31:0] position;
  logic [31:0] velocity;
  logic done_res;

  modport source(output valid, move_duration, position, velocity, done_res, input ready);
  modport sink(input valid, move_duration, position, velocity, done_res, output ready);
endinterface

`default_nettype wire

[sv/trapezoid_motion_profile_unit.sv]
// trapezoid motion profile generator top level
//
//   channel   dir  beat
//   in_ch     in   kind, start_position, target_position, sample_time
//   out_ch    out  move_duration, position, velocity, done_res
//   cfg_*     in   cfg_we, cfg_index, cfg_data (no read-back)
//
// all arithmetic runs on one shared unit. a sample beat uses up to three multiplies.
// a start beat on a triangular move may run a square root (32 square-root bits, two multiplies each).
// a config write restarts planning; the block is not ready until the plan is done.
// reset loads the plan of the reset configuration directly, no clearing pass.
// a finished result waits in the output register while the next beat is accepted.
`timescale 1ns / 1ps
`default_nettype none

module trapezoid_motion_profile_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  tmp_in_if.sink                        in_ch,
  tmp_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [tmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tmp_pkg::Q_W-1:0]       cfg_data
);
  import tmp_pkg::*;

  localparam int DIV_W = Q_W + FRAC_BITS;
  localparam int RES_W = (DIV_W > MX_W) ? DIV_W : MX_W;
  localparam int BIT_W = $clog2(Q_W);
  localparam q_t ONE_Q = q_t'(1) << FRAC_BITS;
  localparam mx_t RMP_RST = mx_t'(1) << (FRAC_BITS - 1);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DIV_TTC = 5'd1;
  localparam logic [4:0] S_RAMP1   = 5'd2;
  localparam logic [4:0] S_RAMP2   = 5'd3;
  localparam logic [4:0] S_DECIDE  = 5'd4;
  localparam logic [4:0] S_CDIV    = 5'd5;
  localparam logic [4:0] S_SQ1     = 5'd6;
  localparam logic [4:0] S_SQ2     = 5'd7;
  localparam logic [4:0] S_DV      = 5'd8;
  localparam logic [4:0] S_PDONE   = 5'd9;
  localparam logic [4:0] S_S0      = 5'd10;
  localparam logic [4:0] S_L1      = 5'd11;
  localparam logic [4:0] S_L2      = 5'd12;
  localparam logic [4:0] S_L3      = 5'd13;
  localparam logic [4:0] S_E1      = 5'd14;
  localparam logic [4:0] S_E2      = 5'd15;
  localparam logic [4:0] S_E3      = 5'd16;
  localparam logic [4:0] S_POS     = 5'd17;
  localparam logic [4:0] S_EMIT    = 5'd18;

  logic [4:0]          state;
  logic                u_wait;
  logic                from_item;
  logic                out_valid;

  // configuration and plan
  q_t                  acc;
  q_t                  mv;
  logic signed [Q_W-1:0] mstart;
  logic signed [Q_W-1:0] mtarget;
  q_t                  ttc;
  q_t                  dtm;
  pos_t                dp;
  q_t                  dv;
  mx_t                 rmp;

  // working registers
  mx_t                 m1;
  q_t                  div_d;
  logic [RMP_W-1:0]    sq_d;
  q_t                  sq_t;
  logic [BIT_W-1:0]    sq_bit;
  logic                tri_mv;
  q_t                  tq;
  q_t                  smp_t;
  logic [RMP_W-1:0]    rm_r;
  pos_t                pos_r;
  q_t                  vel_r;
  q_t                  pend_dur;
  logic                pend_done;

  // output register
  q_t                  out_dur;
  logic signed [Q_W-1:0] out_pos;
  q_t                  out_vel;
  logic                out_done;

  // shared unit
  unit_req_t           u_req;
  logic                u_use;
  logic                u_op;
  logic [RES_W-1:0]    u_a;
  q_t                  u_b;
  logic                u_done;
  logic [RES_W-1:0]    u_res;
  mx_t                 u_mq;
  logic [DIV_W-1:0]    u_q;

  logic                emit;
  q_t                  sq_c;
  logic                sq_ok;
  q_t                  sq_new;
  pos_t                st_s;
  pos_t                tg_s;
  pos_t                rmp_s;
  pos_t                pam;
  pos_t                dpos;
  pos_t                diff;
  pos_t                diff_adj;
  pos_t                half;
  pos_t                mid;
  logic                is_tri;
  pos_t                pp;
  pos_t                d_cru;
  pos_t                d_sq;
  pos_t                mq_s;
  pos_t                mqh_s;
  pos_t                rm_s;
  logic [DIV_W:0]      csum;
  logic [Q_W:0]        dur_w;
  q_t                  dur_sat;
  pos_t                cl;
  pos_t                fin;

  tmp_arith_unit #(
    .FRAC_BITS(FRAC_BITS),
    .RES_W(RES_W)
  ) u_arith (
    .clk(clk),
    .rst(rst),
    .req(u_req),
    .opa(u_a),
    .opb(u_b),
    .done(u_done),
    .res(u_res)
  );

  assign u_mq = u_res[MX_W-1:0];
  assign u_q = u_res[DIV_W-1:0];
  assign u_req.go = u_use && !u_wait && !cfg_we;
  assign u_req.flush = cfg_we;
  assign u_req.op = u_op;

  assign in_ch.ready = (state == S_IDLE) && !cfg_we;
  assign emit = (state == S_EMIT) && (!out_valid || out_ch.ready);

  assign out_ch.valid = out_valid;
  assign out_ch.move_duration = out_dur;
  assign out_ch.position = out_pos;
  assign out_ch.velocity = out_vel;
  assign out_ch.done_res = out_done;

  // square root: trial bit and its acceptance
  assign sq_c = sq_t | (q_t'(1) << sq_bit);
  assign sq_ok = u_mq[MX_W-1:1] <= sq_d;
  assign sq_new = sq_ok ? sq_c : sq_t;

  // plan decision
  assign st_s = {{(POS_W-Q_W){mstart[Q_W-1]}}, mstart};
  assign tg_s = {{(POS_W-Q_W){mtarget[Q_W-1]}}, mtarget};
  assign rmp_s = {{(POS_W-MX_W){1'b0}}, rmp};
  assign pam = st_s + rmp_s;
  assign dpos = tg_s - rmp_s;
  assign diff = tg_s - st_s;
  // halve toward zero
  assign diff_adj = diff + (diff[POS_W-1] ? pos_t'(1) : pos_t'(0));
  assign half = diff_adj >>> 1;
  assign mid = half + st_s;
  assign is_tri = dpos < pam;
  assign pp = is_tri ? mid : dpos;
  assign d_cru = pp - pam;
  assign d_sq = pp - st_s;

  assign mq_s = {{(POS_W-MX_W){1'b0}}, u_mq};
  assign mqh_s = {{(POS_W-RMP_W){1'b0}}, u_mq[MX_W-1:1]};
  assign rm_s = {{(POS_W-RMP_W){1'b0}}, rm_r};
  assign csum = {1'b0, u_q} + (DIV_W+1)'(ttc);

  assign dur_w = (dtm < ttc) ? {dtm, 1'b0} : ({1'b0, dtm} + {1'b0, ttc});
  assign dur_sat = dur_w[Q_W] ? '1 : dur_w[Q_W-1:0];

  assign cl = (pos_r > POS_HI) ? POS_HI : ((pos_r < POS_LO) ? POS_LO : pos_r);
  assign fin = (cl > tg_s) ? tg_s : cl;

  always_comb begin
    u_use = 1'b1;
    u_op = OP_MUL;
    u_a = '0;
    u_b = '0;
    unique case (state)
      S_DIV_TTC: begin
        u_op = OP_DIV;
        u_a = RES_W'({mv, {FRAC_BITS{1'b0}}});
        u_b = acc;
      end
      S_RAMP1: begin
        u_a = RES_W'(acc);
        u_b = ttc;
      end
      S_RAMP2: begin
        u_a = RES_W'(m1);
        u_b = ttc;
      end
      S_CDIV: begin
        u_op = OP_DIV;
        u_a = RES_W'({div_d, {FRAC_BITS{1'b0}}});
        u_b = mv;
      end
      S_SQ1: begin
        u_a = RES_W'(acc);
        u_b = sq_c;
      end
      S_SQ2: begin
        u_a = RES_W'(m1);
        u_b = sq_c;
      end
      S_DV: begin
        u_a = RES_W'(dtm);
        u_b = acc;
      end
      S_L1, S_E1: begin
        u_a = RES_W'(acc);
        u_b = tq;
      end
      S_L2, S_E2: begin
        u_a = RES_W'(m1);
        u_b = tq;
      end
      S_L3: begin
        u_a = RES_W'(dv);
        u_b = tq;
      end
      S_E3: begin
        u_a = RES_W'(tq - ttc);
        u_b = mv;
      end
      default: begin
        u_use = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      u_wait <= 1'b0;
      from_item <= 1'b0;
      out_valid <= 1'b0;
      acc <= ONE_Q;
      mv <= ONE_Q;
      mstart <= '0;
      mtarget <= '0;
      ttc <= ONE_Q;
      dtm <= '0;
      dp <= '0;
      dv <= '0;
      rmp <= RMP_RST;
    end else begin
      if (cfg_we) begin
        u_wait <= 1'b0;
      end else if (u_req.go) begin
        u_wait <= 1'b1;
      end else if (u_done) begin
        u_wait <= 1'b0;
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        // any register write replans from the stored positions
        if (cfg_index == CFG_ACCEL) begin
          acc <= cfg_data;
        end else begin
          mv <= cfg_data;
        end
        from_item <= 1'b0;
        state <= S_DIV_TTC;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (in_ch.valid) begin
              if (in_ch.kind == KIND_START) begin
                mstart <= in_ch.start_position;
                mtarget <= in_ch.target_position;
                from_item <= 1'b1;
                state <= S_DIV_TTC;
              end else begin
                smp_t <= in_ch.sample_time;
                state <= S_S0;
              end
            end
          end
          S_DIV_TTC: begin
            if (u_done) begin
              ttc <= (|u_q[DIV_W-1:Q_W]) ? '1 : u_q[Q_W-1:0];
              state <= S_RAMP1;
            end
          end
          S_RAMP1: begin
            if (u_done) begin
              m1 <= u_mq;
              state <= S_RAMP2;
            end
          end
          S_RAMP2: begin
            if (u_done) begin
              rmp <= {1'b0, u_mq[MX_W-1:1]};
              state <= S_DECIDE;
            end
          end
          S_DECIDE: begin
            tri_mv <= is_tri;
            dp <= pp;
            if (!is_tri) begin
              dv <= mv;
            end
            priority if (pp >= pam) begin
              div_d <= d_cru[Q_W-1:0];
              state <= S_CDIV;
            end else if (pp <= st_s) begin
              dtm <= '0;
              state <= is_tri ? S_DV : S_PDONE;
            end else begin
              sq_d <= d_sq[RMP_W-1:0];
              sq_t <= '0;
              sq_bit <= BIT_W'(Q_W-1);
              state <= S_SQ1;
            end
          end
          S_CDIV: begin
            if (u_done) begin
              dtm <= (|csum[DIV_W:Q_W]) ? '1 : csum[Q_W-1:0];
              state <= tri_mv ? S_DV : S_PDONE;
            end
          end
          S_SQ1: begin
            if (u_done) begin
              m1 <= u_mq;
              state <= S_SQ2;
            end
          end
          S_SQ2: begin
            if (u_done) begin
              sq_t <= sq_new;
              if (sq_bit == '0) begin
                dtm <= sq_new;
                state <= tri_mv ? S_DV : S_PDONE;
              end else begin
                sq_bit <= sq_bit - 1'b1;
                state <= S_SQ1;
              end
            end
          end
          S_DV: begin
            if (u_done) begin
              dv <= (|u_mq[MX_W-1:Q_W]) ? '1 : u_mq[Q_W-1:0];
              state <= S_PDONE;
            end
          end
          S_PDONE: begin
            if (from_item) begin
              pend_dur <= dur_sat;
              pos_r <= '0;
              vel_r <= '0;
              pend_done <= 1'b0;
              state <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end
          S_S0: begin
            if (smp_t >= dtm) begin
              tq <= smp_t - dtm;
              state <= S_L1;
            end else begin
              tq <= smp_t;
              state <= S_E1;
            end
          end
          S_L1: begin
            if (u_done) begin
              // past the stop once the lost velocity exceeds the decel velocity
              if ({{(MX_W-Q_W){1'b0}}, dv} < u_mq) begin
                pos_r <= tg_s;
                vel_r <= '0;
                state <= S_POS;
              end else begin
                m1 <= u_mq;
                state <= S_L2;
              end
            end
          end
          S_L2: begin
            if (u_done) begin
              rm_r <= u_mq[MX_W-1:1];
              state <= S_L3;
            end
          end
          S_L3: begin
            if (u_done) begin
              pos_r <= dp + mq_s - rm_s;
              vel_r <= dv - m1[Q_W-1:0];
              state <= S_POS;
            end
          end
          S_E1: begin
            if (u_done) begin
              m1 <= u_mq;
              vel_r <= (u_mq > {{(MX_W-Q_W){1'b0}}, mv}) ? mv : u_mq[Q_W-1:0];
              state <= (tq <= ttc) ? S_E2 : S_E3;
            end
          end
          S_E2: begin
            if (u_done) begin
              pos_r <= st_s + mqh_s;
              state <= S_POS;
            end
          end
          S_E3: begin
            if (u_done) begin
              pos_r <= st_s + rmp_s + mq_s;
              state <= S_POS;
            end
          end
          S_POS: begin
            pos_r <= fin;
            pend_done <= fin >= tg_s;
            pend_dur <= '0;
            state <= S_EMIT;
          end
          S_EMIT: begin
            if (emit) begin
              out_dur <= pend_dur;
              out_pos <= pos_r[Q_W-1:0];
              out_vel <= vel_r;
              out_done <= pend_done;
              state <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  a_done_expected: assert property (@(posedge clk) disable iff (rst) u_done |-> u_wait)
    else $error("unit result with no operation outstanding");
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_EMIT))
    else $error("result beat raised outside emit");
  a_start_beat_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_dur != '0)) |-> ((out_pos == '0) && (out_vel == '0) && !out_done))
    else $error("start beat carries sample fields");

endmodule

`default_nettype wire

[sv/tmp_arith_unit.sv]
// shared iterative unit: shift-add fixed point multiply and restoring divide
`timescale 1ns / 1ps
`default_nettype none

module tmp_arith_unit #(
  parameter int FRAC_BITS = 16,
  parameter int RES_W = 48
) (
  input  logic                    clk,
  input  logic                    rst,
  input  tmp_pkg::unit_req_t      req,
  input  logic [RES_W-1:0]        opa,
  input  logic [tmp_pkg::Q_W-1:0] opb,
  output logic                    done,
  output logic [RES_W-1:0]        res
);
  import tmp_pkg::*;

  localparam int DIV_W = Q_W + FRAC_BITS;
  localparam int PROD_W = MX_W + Q_W;
  localparam int CNT_W = $clog2(DIV_W);

  logic              busy;
  logic              op_r;
  logic [CNT_W-1:0]  cnt;
  logic [PROD_W-1:0] prod;
  mx_t               mx;
  logic [DIV_W-1:0]  quo;
  q_t                rem;
  q_t                dvs;

  logic              last;
  logic [MX_W:0]     acc_sum;
  logic [Q_W:0]      r2;
  logic [Q_W:0]      r2_sub;
  logic              ge;
  logic [PROD_W-1:0] shifted;
  mx_t               mq;

  assign last = (op_r == OP_MUL) ? (cnt == CNT_W'(Q_W-1)) : (cnt == CNT_W'(DIV_W-1));
  assign acc_sum = {1'b0, prod[PROD_W-1:Q_W]} + (prod[0] ? {1'b0, mx} : '0);
  assign r2 = {rem, quo[DIV_W-1]};
  assign ge = r2 >= {1'b0, dvs};
  assign r2_sub = r2 - {1'b0, dvs};
  assign shifted = prod >> FRAC_BITS;
  assign mq = (shifted > PROD_W'(SAT_CAP)) ? SAT_CAP : shifted[MX_W-1:0];
  assign res = (op_r == OP_MUL) ? RES_W'(mq) : RES_W'(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op_r <= OP_MUL;
      cnt <= '0;
    end else if (req.flush) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        op_r <= req.op;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one product bit or one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (req.go) begin
      if (req.op == OP_MUL) begin
        prod <= {{MX_W{1'b0}}, opb};
        mx <= opa[MX_W-1:0];
      end else begin
        quo <= opa[DIV_W-1:0];
        rem <= '0;
        dvs <= opb;
      end
    end else if (busy) begin
      if (op_r == OP_MUL) begin
        prod <= {acc_sum, prod[Q_W-1:1]};
      end else begin
        rem <= ge ? r2_sub[Q_W-1:0] : r2[Q_W-1:0];
        quo <= {quo[DIV_W-2:0], ge};
      end
    end
  end

  a_no_go_busy: assert property (@(posedge clk) disable iff (rst) req.go |-> !busy)
    else $error("unit started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("unit done without a running operation");
  a_busy_ends: assert property (@(posedge clk) disable iff (rst)
    (busy && !req.flush) |=> (busy || done))
    else $error("unit operation dropped");

endmodule

`default_nettype wire
